// File: rtl/core/csv_field_deframer_unit_macros.svh
// ----------------------------------------------------------------------------
// CSV field deframer assertion macros
// Shorthand for the concurrent checks used in the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_DEFRAMER_UNIT_MACROS_SVH
`define CSV_FIELD_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/cfd_pkg.sv
// ----------------------------------------------------------------------------
// CSV field deframer package
// Shared payload types, character codes and parameter defaults.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int MAX_FIELD_DEF    = 127;
  localparam int GRID_COLUMNS_DEF = 256;
  localparam int GRID_ROWS_DEF    = 1024;

  localparam int LENGTH_W = 7;
  localparam int COLUMN_W = 9;
  localparam int ROW_W    = 11;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } text_item_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                byte_valid;
    logic                field_end;
    logic [LENGTH_W-1:0] field_length;
    logic                line_end;
    logic                file_end;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
  } field_item_t;

  // Result of one parser step.
  typedef struct packed {
    logic        has_result;
    field_item_t result;
  } step_out_t;

endpackage

// File: rtl/core/cfd_stream_if.sv
// ----------------------------------------------------------------------------
// CSV field deframer stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface cfd_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// File: rtl/core/cfd_parse_step.sv
// ----------------------------------------------------------------------------
// CSV field deframer parse step
// Parser state machine, field/column/row counters and per-item result logic.
// ----------------------------------------------------------------------------
module cfd_parse_step #(
  parameter int MAX_FIELD    = cfd_pkg::MAX_FIELD_DEF,
  parameter int GRID_COLUMNS = cfd_pkg::GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = cfd_pkg::GRID_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  cfd_pkg::text_item_t item,
  output cfd_pkg::step_out_t  step
);
  import cfd_pkg::*;

  localparam int KEPT_W = $clog2(MAX_FIELD + 1);
  localparam int COL_W  = $clog2(GRID_COLUMNS + 1);
  localparam int ROWC_W = $clog2(GRID_ROWS + 1);

  typedef enum logic [2:0] {
    PH_START,
    PH_PLAIN,
    PH_QUOTED,
    PH_QUOTE_SEEN,
    PH_AFTER_CR,
    PH_DONE
  } phase_t;

  phase_t              phase, phase_next;
  logic [KEPT_W-1:0]   kept, kept_next;
  logic [COL_W-1:0]    col, col_next;
  logic [ROWC_W-1:0]   row, row_next;

  logic do_emit, do_end, end_eol, end_eof, eof_only;
  logic is_quote, is_comma, is_cr, is_lf, eof;

  assign eof      = item.end_of_file;
  assign is_quote = (item.in_byte == CHAR_QUOTE);
  assign is_comma = (item.in_byte == CHAR_COMMA);
  assign is_cr    = (item.in_byte == CHAR_CR);
  assign is_lf    = (item.in_byte == CHAR_LF);

  always_comb begin
    phase_next = phase;
    do_emit    = 1'b0;
    do_end     = 1'b0;
    end_eol    = 1'b0;
    end_eof    = 1'b0;
    eof_only   = 1'b0;
    case (phase)
      PH_START: begin
        if (eof) begin
          eof_only   = 1'b1;
          phase_next = PH_DONE;
        end else if (is_quote) begin
          phase_next = PH_QUOTED;
        end else if (is_comma) begin
          do_end = 1'b1;
        end else if (is_lf) begin
          do_end  = 1'b1;
          end_eol = 1'b1;
        end else begin
          phase_next = PH_PLAIN;
          do_emit    = !is_cr;
        end
      end
      PH_PLAIN: begin
        if (eof) begin
          do_end  = 1'b1;
          end_eol = 1'b1;
          end_eof = 1'b1;
        end else if (is_comma) begin
          do_end = 1'b1;
        end else if (is_lf) begin
          do_end  = 1'b1;
          end_eol = 1'b1;
        end else begin
          do_emit = !is_cr;
        end
      end
      PH_QUOTED: begin
        if (eof) begin
          do_end  = 1'b1;
          end_eof = 1'b1;
        end else if (is_quote) begin
          phase_next = PH_QUOTE_SEEN;
        end else begin
          do_emit = 1'b1;
        end
      end
      PH_QUOTE_SEEN: begin
        if (eof) begin
          do_end  = 1'b1;
          end_eol = 1'b1;
          end_eof = 1'b1;
        end else if (is_quote) begin
          phase_next = PH_QUOTED;
          do_emit    = 1'b1;
        end else if (is_cr) begin
          phase_next = PH_AFTER_CR;
        end else begin
          do_end  = 1'b1;
          end_eol = is_lf;
        end
      end
      PH_AFTER_CR: begin
        do_end  = 1'b1;
        end_eol = eof || is_lf;
        end_eof = eof;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    kept_next = kept;
    col_next  = col;
    row_next  = row;

    step.has_result          = 1'b0;
    step.result.out_byte     = '0;
    step.result.byte_valid   = 1'b0;
    step.result.field_end    = 1'b0;
    step.result.field_length = '0;
    step.result.line_end     = 1'b0;
    step.result.file_end     = 1'b0;
    step.result.column       = COLUMN_W'(col);
    step.result.row          = ROW_W'(row);

    if (eof_only) begin
      step.has_result        = 1'b1;
      step.result.file_end   = 1'b1;
    end

    // Characters past the field limit are dropped without a result.
    if (do_emit && (kept < KEPT_W'(MAX_FIELD))) begin
      kept_next              = kept + 1'b1;
      step.has_result        = 1'b1;
      step.result.out_byte   = item.in_byte;
      step.result.byte_valid = 1'b1;
    end

    if (do_end) begin
      step.has_result          = 1'b1;
      step.result.field_end    = 1'b1;
      step.result.field_length = LENGTH_W'(kept);
      step.result.line_end     = end_eol;
      step.result.file_end     = end_eof;
      kept_next                = '0;
      if (end_eol) begin
        col_next = '0;
        if (row < ROWC_W'(GRID_ROWS)) begin
          row_next = row + 1'b1;
        end
      end else if (col < COL_W'(GRID_COLUMNS)) begin
        col_next = col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      kept  <= '0;
      col   <= '0;
      row   <= '0;
    end else if (advance) begin
      phase <= do_end ? (end_eof ? PH_DONE : PH_START) : phase_next;
      kept  <= kept_next;
      col   <= col_next;
      row   <= row_next;
    end
  end

endmodule

// File: rtl/core/csv_field_deframer_unit.sv
// ----------------------------------------------------------------------------
// CSV field deframer
// Splits a CSV byte stream into fields, passing out kept characters and
// reporting length, column and row at every field end.
// ----------------------------------------------------------------------------
// Usage:
//   The text channel carries one transfer per input byte, or one transfer
//   with end_of_file set to close the stream. The fields channel carries at
//   most one result per input transfer: a kept field character, a field end
//   with its length, column and row, or a bare end-of-file mark.
//   An input transfer lands in the input register; the parser step evaluates it
//   there and loads the result register once that register is free or being
//   emptied. One input transfer is taken every cycle as long as the receiver
//   keeps ready high. The rate is set by the single parser step between the
//   input and result registers, which updates state and counters once per
//   cycle while it takes an item.
//   When the receiver stalls, the result register holds its transfer and the
//   input register holds one more item; text.ready then drops until the
//   result is taken. Inputs that give no result also wait until the result
//   register is free or being emptied.
//   Reset (synchronous, active high) empties both registers and returns the
//   parser to the start of a field at column 0, row 0. After end of file all
//   further input transfers are accepted and dropped until the next reset.
// ----------------------------------------------------------------------------
`include "csv_field_deframer_unit_macros.svh"

module csv_field_deframer_unit #(
  parameter int MAX_FIELD    = cfd_pkg::MAX_FIELD_DEF,
  parameter int GRID_COLUMNS = cfd_pkg::GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = cfd_pkg::GRID_ROWS_DEF
) (
  input logic      clk,
  input logic      rst,
  cfd_stream_if.sink   text,
  cfd_stream_if.source fields
);
  import cfd_pkg::*;

  // Input register: one text item waiting for the parser step.
  text_item_t  item_q;
  logic        item_valid;

  // Result register feeding the fields channel.
  field_item_t result_q;
  logic        result_valid;

  step_out_t   step;
  logic        consume;

  // The parser step takes the held item whenever the result register is free
  // or being emptied in this cycle, whether or not the item gives a result.
  assign consume    = item_valid && (!result_valid || fields.ready);
  assign text.ready = !item_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      item_valid <= 1'b1;
    end else if (consume) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      item_q <= text.payload;
    end
  end

  cfd_parse_step #(
    .MAX_FIELD    (MAX_FIELD),
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (consume),
    .item    (item_q),
    .step    (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (consume && step.has_result) begin
      result_valid <= 1'b1;
    end else if (fields.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && step.has_result) begin
      result_q <= step.result;
    end
  end

  assign fields.valid   = result_valid;
  assign fields.payload = result_q;

  // A delivered end-of-file result is the last one until reset.
  `CFD_ASSERT_NEXT(a_eof_last, fields.valid && fields.ready && fields.payload.file_end, !fields.valid, "result after end of file")

  // A stalled result keeps the held input item in place.
  `CFD_ASSERT_NEXT(a_item_held, item_valid && result_valid && !fields.ready, item_valid && $stable(item_q), "input item lost during stall")

  // A result carries either a character or a field end, never both.
  `CFD_ASSERT_NOW(a_one_kind, fields.valid, !(fields.payload.byte_valid && fields.payload.field_end), "character and field end together")

  // Reported field length never exceeds the field limit.
  `CFD_ASSERT_NOW(a_len_limit, fields.valid, 32'(fields.payload.field_length) <= MAX_FIELD, "field length above limit")

endmodule
